// ----- rtl/hsc_pkg.sv -----
package hsc_pkg;

  localparam int WORD_W          = 63;
  localparam int LEN_W           = 6;
  localparam int SYN_W           = 6;
  localparam int PAR_W           = 3;
  localparam int MAX_DATA_BITS_D = 57;
  localparam logic [LEN_W-1:0] DATA_LENGTH_RST = LEN_W'(57);

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_type_t;

  // Derived code geometry for the length currently in use.
  typedef struct packed {
    logic [LEN_W-1:0]  m;
    logic [SYN_W-1:0]  n;
    logic [WORD_W-1:0] data_mask;
    logic [WORD_W-1:0] cw_mask;
  } len_info_t;

  function automatic logic is_pow2(input int p);
    return (p & (p - 1)) == 0;
  endfunction

  // Least r with 2^r >= m + r + 1.
  function automatic logic [PAR_W-1:0] parity_count(input logic [LEN_W-1:0] m);
    logic [PAR_W-1:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if ((1 << i) >= int'(m) + i + 1) begin
        r = PAR_W'(i);
      end
    end
    return r;
  endfunction

  // Data bit k goes to the k-th position that is not a power of two.
  function automatic logic [WORD_W-1:0] scatter_data(input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] c;
    int k;
    c = '0;
    k = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if (!is_pow2(p)) begin
        c[p-1] = d[k];
        k++;
      end
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] gather_data(input logic [WORD_W-1:0] c);
    logic [WORD_W-1:0] d;
    int k;
    d = '0;
    k = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if (!is_pow2(p)) begin
        d[k] = c[p-1];
        k++;
      end
    end
    return d;
  endfunction

  // Bit b of the syndrome is the parity of all positions with bit b set.
  function automatic logic [SYN_W-1:0] calc_syndrome(input logic [WORD_W-1:0] c);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int b = 0; b < SYN_W; b++) begin
      for (int j = 1; j <= WORD_W; j++) begin
        if (((j >> b) & 1) == 1) begin
          s[b] = s[b] ^ c[j-1];
        end
      end
    end
    return s;
  endfunction

endpackage

// ----- rtl/hsc_len_dec.sv -----
module hsc_len_dec #(
  parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_D
) (
  input  logic [hsc_pkg::LEN_W-1:0] data_length,
  output hsc_pkg::len_info_t        info
);
  import hsc_pkg::*;

  logic [LEN_W-1:0] m_eff;
  logic [PAR_W-1:0] r;

  // Out-of-range lengths are clamped; the register keeps what was written.
  always_comb begin
    priority if (data_length == '0) begin
      m_eff = LEN_W'(1);
    end else if (data_length > LEN_W'(MAX_DATA_BITS)) begin
      m_eff = LEN_W'(MAX_DATA_BITS);
    end else begin
      m_eff = data_length;
    end
  end

  assign r = parity_count(m_eff);

  always_comb begin
    info.m         = m_eff;
    info.n         = m_eff + {{(LEN_W-PAR_W){1'b0}}, r};
    info.data_mask = WORD_W'((64'd1 << m_eff) - 64'd1);
    info.cw_mask   = WORD_W'((64'd1 << info.n) - 64'd1);
  end

endmodule

// ----- rtl/hamming_sec_codec_unit.sv -----
// Shortened Hamming single-error-correcting encoder and decoder.
//
// Input channel: an item is transferred at a rising edge where start is high
// and busy is low. in_req_type selects encode (data word in, codeword out) or
// decode (received codeword in, corrected data out). busy is high while reset
// is applied and falls at the first clock edge after reset is released. From then on
// one item can be transferred every cycle.
//
// Result channel: each result is shown for exactly one cycle with out_valid
// high, after the three register stages. The receiver cannot stall the
// block, so results are never held and never dropped.
//
// Configuration: cfg_data is written into the data length register when
// cfg_valid and cfg_ready are both high. It should only change while no items
// are in flight. Reset loads a data length of 57.
//
// Throughput is one item per cycle while busy is low. The three register
// stages are length masking, data scatter plus syndrome trees, and
// error correction plus data gather into the output registers.
module hamming_sec_codec_unit #(
  parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [hsc_pkg::WORD_W-1:0]  in_word_in,
  output logic                        out_valid,
  output logic [hsc_pkg::WORD_W-1:0]  out_word_out,
  output logic [hsc_pkg::SYN_W-1:0]   out_syndrome,
  output logic                        out_corrected,
  output logic                        out_syndrome_invalid,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsc_pkg::LEN_W-1:0]   cfg_data
);
  import hsc_pkg::*;

  logic              busy_r;
  logic [LEN_W-1:0]  data_length_r;
  len_info_t         len_info;
  logic              accept;

  // Stage 1: input word trimmed to the active length.
  logic              v1_r;
  req_type_t         s1_req_r;
  logic [WORD_W-1:0] s1_word_r;
  logic [SYN_W-1:0]  s1_n_r;

  // Stage 2: codeword layout and its syndrome.
  logic              v2_r;
  req_type_t         s2_req_r;
  logic [WORD_W-1:0] s2_cw_r;
  logic [SYN_W-1:0]  s2_syn_r;
  logic [SYN_W-1:0]  s2_n_r;
  logic [WORD_W-1:0] s2_cw_nxt;

  // Stage 3: output registers.
  logic              out_valid_r;
  logic [WORD_W-1:0] word_out_r;
  logic [SYN_W-1:0]  syndrome_r;
  logic              corrected_r;
  logic              syn_inval_r;
  logic [WORD_W-1:0] word_out_nxt;
  logic [SYN_W-1:0]  syndrome_nxt;
  logic              corrected_nxt;
  logic              syn_inval_nxt;

  // The block is only held off by reset; busy is a registered copy of it.
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r <= DATA_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      data_length_r <= cfg_data;
    end
  end

  hsc_len_dec #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_len_dec (
    .data_length(data_length_r),
    .info       (len_info)
  );

  // Encode ignores data bits at index m and above; decode reads positions
  // above n as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r  <= req_type_t'(in_req_type);
      s1_word_r <= (in_req_type == REQ_DECODE) ? (in_word_in & len_info.cw_mask)
                                               : (in_word_in & len_info.data_mask);
      s1_n_r    <= len_info.n;
    end
  end

  // For encode the parity positions are still zero, so the syndrome of the
  // scattered word is exactly the set of parity bits to insert.
  assign s2_cw_nxt = (s1_req_r == REQ_DECODE) ? s1_word_r : scatter_data(s1_word_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      s2_req_r <= s1_req_r;
      s2_cw_r  <= s2_cw_nxt;
      s2_syn_r <= calc_syndrome(s2_cw_nxt);
      s2_n_r   <= s1_n_r;
    end
  end

  // A nonzero syndrome within the codeword flips that position; one beyond
  // the codeword is reported as invalid and the word is left alone.
  always_comb begin
    logic [WORD_W-1:0] fixed;
    logic [WORD_W-1:0] parity_bits;
    fixed       = s2_cw_r;
    parity_bits = '0;
    for (int b = 0; b < SYN_W; b++) begin
      parity_bits[(1 << b) - 1] = s2_syn_r[b];
    end
    unique case (s2_req_r)
      REQ_ENCODE: begin
        word_out_nxt  = s2_cw_r | parity_bits;
        syndrome_nxt  = '0;
        corrected_nxt = 1'b0;
        syn_inval_nxt = 1'b0;
      end
      REQ_DECODE: begin
        corrected_nxt = (s2_syn_r != '0) && (s2_syn_r <= s2_n_r);
        syn_inval_nxt = (s2_syn_r != '0) && (s2_syn_r > s2_n_r);
        if (corrected_nxt) begin
          fixed = s2_cw_r ^ (WORD_W'(1) << (s2_syn_r - SYN_W'(1)));
        end
        word_out_nxt  = gather_data(fixed);
        syndrome_nxt  = s2_syn_r;
      end
      default: begin
        word_out_nxt  = '0;
        syndrome_nxt  = '0;
        corrected_nxt = 1'b0;
        syn_inval_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      word_out_r  <= word_out_nxt;
      syndrome_r  <= syndrome_nxt;
      corrected_r <= corrected_nxt;
      syn_inval_r <= syn_inval_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_word_out         = word_out_r;
  assign out_syndrome         = syndrome_r;
  assign out_corrected        = corrected_r;
  assign out_syndrome_invalid = syn_inval_r;

endmodule

// ----- rtl/hsc_checker.sv -----
module hsc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [hsc_pkg::SYN_W-1:0]  out_syndrome,
  input logic                       out_corrected,
  input logic                       out_syndrome_invalid
);
  import hsc_pkg::*;

  // Every transfer in yields exactly one result, and every result has a transfer.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after input transfer");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching input transfer");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_corrected && out_syndrome_invalid))
    else $error("corrected and syndrome_invalid both set");

  a_flags_syn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_corrected || out_syndrome_invalid)) |-> (out_syndrome != '0))
    else $error("error flag set with a zero syndrome");

endmodule

bind hamming_sec_codec_unit hsc_checker u_hsc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_syndrome        (out_syndrome),
  .out_corrected       (out_corrected),
  .out_syndrome_invalid(out_syndrome_invalid)
);

// ----- tb/tb_hamming_sec_codec_unit.sv -----
// Testbench for the shortened Hamming single-error-correcting codec.
//
// A scoreboard object predicts every transfer that the block accepts. The
// prediction uses the data length that the testbench last wrote. Each strobed
// result is checked field by field against the oldest prediction.
//
// The run has two parts. A short directed part covers the extreme data words,
// both request types, correction at the first and last positions, junk above
// the codeword length, and a syndrome that points past the end of a shortened
// codeword. A long random part then sweeps the data length over its legal and
// out-of-range values. Most decode requests in that part are real codewords
// carrying zero, one or two flipped bits, and the rest are plain noise.
module tb_hamming_sec_codec_unit;
  import hsc_pkg::*;

  // The pipeline is three register stages deep. The block also holds busy and the length register.
  localparam int PIPE_LATENCY = 3;
  localparam int PHASE_ITEMS  = 80;
  localparam int CYCLE_LIMIT  = 200000;

  // Data lengths for the random sweep, after the two directed settings (57 and
  // 2). Zero and values above the maximum are clamped by the block. The
  // register still keeps the value that was written.
  localparam logic [LEN_W-1:0] SWEEP [12] = '{
    6'd1, 6'd0, 6'd3, 6'd4, 6'd63, 6'd58, 6'd11, 6'd26, 6'd27, 6'd56, 6'd57, 6'd5
  };
  // The sweep entry at this index runs with no idle cycles on the input side.
  localparam int STEADY_PHASE = 4;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct {
    word_t            word;
    logic [SYN_W-1:0] syn;
    logic             corr;
    logic             inval;
  } codec_result_t;

  class codec_scoreboard;
    codec_result_t    pending[$];
    logic [LEN_W-1:0] data_length;
    int               errors;

    function new();
      data_length = DATA_LENGTH_RST;
      errors = 0;
    endfunction

    static function int data_bits(input logic [LEN_W-1:0] len);
      int m;
      m = int'(len);
      if (m < 1) m = 1;
      if (m > MAX_DATA_BITS_D) m = MAX_DATA_BITS_D;
      return m;
    endfunction

    static function int code_bits(input logic [LEN_W-1:0] len);
      int m;
      int r;
      m = data_bits(len);
      r = 0;
      while ((1 << r) < m + r + 1) r++;
      return m + r;
    endfunction

    static function codec_result_t predict(input req_type_t rq, input word_t w,
                                           input logic [LEN_W-1:0] len);
      codec_result_t res;
      word_t         cw;
      int            n;
      int            k;
      int            syn;
      logic          par;
      n = code_bits(len);
      res.word = '0;
      res.syn = '0;
      res.corr = 1'b0;
      res.inval = 1'b0;
      k = 0;
      if (rq == REQ_ENCODE) begin
        // Data bits go to the positions that are not powers of two. Input bits
        // beyond the data length are never picked up.
        for (int pos = 1; pos <= n; pos++) begin
          if ((pos & (pos - 1)) != 0) begin
            res.word[pos-1] = w[k];
            k++;
          end
        end
        for (int p = 1; p <= n; p = p << 1) begin
          par = 1'b0;
          for (int j = 1; j <= n; j++) begin
            if ((j & p) != 0) par = par ^ res.word[j-1];
          end
          res.word[p-1] = par;
        end
      end else begin
        // Received positions above the codeword length read as zero.
        cw = w;
        for (int j = n; j < WORD_W; j++) cw[j] = 1'b0;
        syn = 0;
        for (int p = 1; p <= n; p = p << 1) begin
          par = 1'b0;
          for (int j = 1; j <= n; j++) begin
            if ((j & p) != 0) par = par ^ cw[j-1];
          end
          if (par) syn = syn | p;
        end
        if (syn != 0) begin
          if (syn <= n) begin
            cw[syn-1] = ~cw[syn-1];
            res.corr = 1'b1;
          end else begin
            // The syndrome points past the shortened codeword. It is reported
            // and the word is passed through as received.
            res.inval = 1'b1;
          end
        end
        res.syn = SYN_W'(syn);
        for (int pos = 1; pos <= n; pos++) begin
          if ((pos & (pos - 1)) != 0) begin
            res.word[k] = cw[pos-1];
            k++;
          end
        end
      end
      return res;
    endfunction

    function void note_input(input req_type_t rq, input word_t w);
      pending.insert(pending.size(), predict(rq, w, data_length));
    endfunction

    function void compare(input string field, input logic [63:0] exp,
                          input logic [63:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, field, exp, act);
      end
    endfunction

    function void check_result(input word_t w, input logic [SYN_W-1:0] s,
                               input logic c, input logic i);
      codec_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no transfer pending, word_out expected none actual %h",
                 $time, w);
        return;
      end
      exp = pending.pop_front();
      compare("word_out", 64'(exp.word), 64'(w));
      compare("syndrome", 64'(exp.syn), 64'(s));
      compare("corrected", 64'(exp.corr), 64'(c));
      compare("syndrome_invalid", 64'(exp.inval), 64'(i));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_req_type;
  word_t            in_word_in;
  logic             out_valid;
  word_t            out_word_out;
  logic [SYN_W-1:0] out_syndrome;
  logic             out_corrected;
  logic             out_syndrome_invalid;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;

  codec_scoreboard sb;
  bit              steady;
  int              cycles;

  hamming_sec_codec_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_word_in           (in_word_in),
    .out_valid            (out_valid),
    .out_word_out         (out_word_out),
    .out_syndrome         (out_syndrome),
    .out_corrected        (out_corrected),
    .out_syndrome_invalid (out_syndrome_invalid),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Both channels are sampled at the clock edge, before any of the values
  // driven at that edge take effect. An input transfer is noted in the same
  // cycle in which the block takes it.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
      sb.note_input(req_type_t'(in_req_type), in_word_in);
    end
    if (out_valid === 1'b1) begin
      sb.check_result(out_word_out, out_syndrome, out_corrected, out_syndrome_invalid);
    end
  end

  function automatic word_t rand_word();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[WORD_W-1:0];
  endfunction

  function automatic word_t codeword_of(input word_t data);
    codec_result_t r;
    r = codec_scoreboard::predict(REQ_ENCODE, data, sb.data_length);
    return r.word;
  endfunction

  // Presents one request and holds it until the block takes it. Now and then
  // the input side goes idle afterward. Start is lowered only
  // in a cycle where the next request is not raised again.
  task automatic send_item(input req_type_t rq, input word_t w);
    start <= 1'b1;
    in_req_type <= rq;
    in_word_in <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (!steady && $urandom_range(99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // The length register changes only while the pipeline is empty. The extra
  // cycles after the last result cover the full pipeline depth.
  task automatic write_length(input logic [LEN_W-1:0] v);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.data_length = v;
  endtask

  // A random request. Most decodes are real codewords with zero, one or two
  // flipped positions. Some also carry junk above the codeword length, which
  // the block must ignore.
  task automatic random_item();
    int    sel;
    int    n;
    int    i;
    int    j;
    word_t w;
    word_t above;
    n = codec_scoreboard::code_bits(sb.data_length);
    sel = $urandom_range(99);
    w = rand_word();
    if (sel < 20) begin
      send_item(REQ_ENCODE, w);
    end else if (sel < 30) begin
      send_item(REQ_DECODE, w);
    end else begin
      w = codeword_of(w);
      i = $urandom_range(n - 1);
      j = $urandom_range(n - 1);
      if (sel < 75) begin
        w[i] = ~w[i];
      end else if (sel < 85 && i != j) begin
        w[i] = ~w[i];
        w[j] = ~w[j];
      end
      if ($urandom_range(3) == 0) begin
        above = '1;
        above = above << n;
        w = w | (rand_word() & above);
      end
      send_item(REQ_DECODE, w);
    end
  endtask

  task automatic random_phase();
    repeat (PHASE_ITEMS) random_item();
  endtask

  initial begin
    word_t w;
    sb = new();
    cycles <= 0;
    steady <= 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= REQ_ENCODE;
    in_word_in <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset length of 57, where the codeword fills
    // all 63 positions.
    send_item(REQ_ENCODE, '0);
    send_item(REQ_ENCODE, '1);
    send_item(REQ_ENCODE, word_t'(1));
    send_item(REQ_ENCODE, word_t'(1) << 56);
    // Only a data bit beyond the data length is set, so the codeword is zero.
    send_item(REQ_ENCODE, word_t'(1) << 57);
    send_item(REQ_DECODE, '0);
    send_item(REQ_DECODE, '1);
    w = codeword_of(rand_word());
    send_item(REQ_DECODE, w);
    send_item(REQ_DECODE, w ^ word_t'(1));
    send_item(REQ_DECODE, w ^ (word_t'(1) << 62));
    send_item(REQ_DECODE, w ^ (word_t'(1) << 36));
    random_phase();

    // Two data bits give a five-position codeword whose syndrome can reach 7.
    write_length(6'd2);
    // Parity positions 1, 2 and 4 all set give a syndrome of 7, which is past
    // the end of the codeword.
    send_item(REQ_DECODE, word_t'('b1011));
    // A set bit at position 6 lies above the codeword and must read as zero.
    send_item(REQ_DECODE, word_t'(1) << 5);
    send_item(REQ_ENCODE, word_t'(3));
    send_item(REQ_ENCODE, '1);
    w = codeword_of(word_t'(3));
    send_item(REQ_DECODE, w ^ (word_t'(1) << 4));
    random_phase();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 12) begin
        write_length(SWEEP[ph]);
      end else begin
        write_length(LEN_W'($urandom_range(0, 63)));
      end
      steady <= (ph == STEADY_PHASE);
      random_phase();
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // Any extra result that comes out after the last expected one is caught
    // by the monitor during this tail.
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hsc_pkg.sv
rtl/hsc_len_dec.sv
rtl/hamming_sec_codec_unit.sv
rtl/hsc_checker.sv
tb/tb_hamming_sec_codec_unit.sv
